// ===== hdl/display_list_texture_ref_scanner_top_macros.svh =====
// ----------------------------------------------------------------------------
// display_list_texture_ref_scanner_top_macros
// assertion macros shared by the scanner modules, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LIST_TEXTURE_REF_SCANNER_TOP_MACROS_SVH
`define DISPLAY_LIST_TEXTURE_REF_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge out of reset
`define DLTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked only where an enable term holds
`define DLTR_ASSERT_IF(lbl, en, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (prop)) else $error(msg);
`else
`define DLTR_ASSERT(lbl, prop, msg)
`define DLTR_ASSERT_IF(lbl, en, prop, msg)
`endif

`endif

// ===== hdl/dltr_pkg.sv =====
// ----------------------------------------------------------------------------
// dltr_pkg
// constants, opcodes and control structs of the texture reference scanner
// ----------------------------------------------------------------------------
package dltr_pkg;

  // seen address table
  localparam int SEEN_DEPTH = 256;
  localparam int SEEN_AW    = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int SEEN_CW    = $clog2(SEEN_DEPTH + 1);

  // tile descriptor slots and opcode history length
  localparam int TILE_SLOTS = 8;
  localparam int TILE_AW    = $clog2(TILE_SLOTS);
  localparam int HIST_LEN   = 6;

  // command opcodes
  localparam logic [7:0] OP_SETTIMG     = 8'hFD;
  localparam logic [7:0] OP_SETTILE     = 8'hF5;
  localparam logic [7:0] OP_SETTILESIZE = 8'hF2;
  localparam logic [7:0] OP_LOADBLOCK   = 8'hF3;
  localparam logic [7:0] OP_LOADTLUT    = 8'hF0;
  localparam logic [7:0] OP_RDPLOADSYNC = 8'hE6;
  localparam logic [7:0] OP_RDPPIPESYNC = 8'hE7;
  localparam logic [7:0] OP_RDPTILESYNC = 8'hE8;
  localparam logic [7:0] OP_ENDDL       = 8'hDF;

  // image formats and texel sizes
  localparam logic [2:0] FMT_RGBA = 3'd0;
  localparam logic [2:0] FMT_IA   = 3'd3;
  localparam logic [1:0] SIZ_4B   = 2'd0;
  localparam logic [1:0] SIZ_8B   = 2'd1;
  localparam logic [1:0] SIZ_16B  = 2'd2;
  localparam logic [1:0] SIZ_32B  = 2'd3;

  // segment holding the tracked data
  localparam logic [7:0] SEG_TEXTURE = 8'h02;

  // reference kinds
  localparam logic KIND_TEXTURE = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic rd_issue;
    logic idx_inc;
    logic emit;
  } dltr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cand;
    logic scan_end;
    logic hit;
    logic out_free;
  } dltr_stat_t;

endpackage

// ===== hdl/dltr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dltr_ctrl
// sequencer for decode, seen table search and result hand-off
// ----------------------------------------------------------------------------
`include "display_list_texture_ref_scanner_top_macros.svh"

module dltr_ctrl
  import dltr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dltr_stat_t stat,
  output dltr_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_RD     = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = stat.cand ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        state_nxt = stat.scan_end ? ST_EMIT : ST_CMP;
      end
      ST_CMP: begin
        state_nxt = stat.hit ? ST_IDLE : ST_RD;
      end
      ST_EMIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands to the datapath
  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.capture  = (state_r == ST_IDLE) && in_valid;
  assign cmd.decode   = (state_r == ST_DECODE);
  assign cmd.rd_issue = (state_r == ST_RD) && !stat.scan_end;
  assign cmd.idx_inc  = (state_r == ST_CMP) && !stat.hit;
  assign cmd.emit     = (state_r == ST_EMIT) && stat.out_free;

  // a known address drops the reference and frees the block
  `DLTR_ASSERT_IF(a_hit_drops, (state_r == ST_CMP) && stat.hit, ##1 (state_r == ST_IDLE), "hit did not return to idle")
  // commands without a reference go straight back to idle
  `DLTR_ASSERT_IF(a_no_cand_idle, (state_r == ST_DECODE) && !stat.cand, ##1 in_ready, "no-reference transaction stalled input")

endmodule

// ===== hdl/dltr_datapath.sv =====
// ----------------------------------------------------------------------------
// dltr_datapath
// command decode state, seen address table and result register
// ----------------------------------------------------------------------------
`include "display_list_texture_ref_scanner_top_macros.svh"

module dltr_datapath
  import dltr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] in_word_high,
  input  logic [31:0] in_word_low,
  input  logic        in_list_start,
  input  dltr_cmd_t   cmd,
  output dltr_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ref_kind,
  output logic [31:0] out_segment_address,
  output logic [10:0] out_width,
  output logic [10:0] out_height,
  output logic [22:0] out_byte_size,
  output logic [10:0] out_palette_count,
  output logic [2:0]  out_pixel_format,
  output logic [1:0]  out_bit_size,
  output logic        out_not_recorded
);

  // captured command
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic        ls_r;

  // list state
  logic [7:0] hist_r [HIST_LEN];
  logic [2:0] tile_fmt_r [TILE_SLOTS];
  logic [1:0] tile_bs_r [TILE_SLOTS];
  logic [2:0] img_fmt_r;
  logic [1:0] img_bs_r;
  logic [31:0] img_seg_r;

  // seen table and search
  logic [31:0]        seen_mem [SEEN_DEPTH];
  logic [31:0]        rd_data_r;
  logic [SEEN_CW-1:0] cnt_r;
  logic [SEEN_CW-1:0] idx_r;

  // staged reference
  logic        st_kind_r;
  logic [31:0] st_addr_r;
  logic [10:0] st_w_r;
  logic [10:0] st_h_r;
  logic [20:0] st_prod_r;
  logic [10:0] st_cnt_r;
  logic [2:0]  st_fmt_r;
  logic [1:0]  st_bs_r;

  // decode of the captured command
  logic [7:0]         op;
  logic [TILE_AW-1:0] tile_idx;
  logic [10:0]        dim_w;
  logic [10:0]        dim_h;
  logic               tex_seq;
  logic               pal_seq;
  logic               tex_hit;
  logic               pal_hit;
  logic               table_room;
  logic [22:0]        byte_nxt;

  assign op       = hi_r[31:24];
  assign tile_idx = lo_r[24 +: TILE_AW];
  assign dim_w    = {1'b0, lo_r[23:14]} + 11'd1;
  assign dim_h    = {1'b0, lo_r[11:2]} + 11'd1;

  // opcode sequences, most recent first
  assign tex_seq = (hist_r[0] == OP_SETTILE) && (hist_r[1] == OP_RDPPIPESYNC) &&
                   (hist_r[2] == OP_LOADBLOCK) && (hist_r[3] == OP_RDPLOADSYNC) &&
                   (hist_r[4] == OP_SETTILE) && (hist_r[5] == OP_SETTIMG);
  assign pal_seq = (hist_r[0] == OP_RDPLOADSYNC) && (hist_r[1] == OP_SETTILE) &&
                   (hist_r[2] == OP_RDPTILESYNC) && (hist_r[3] == OP_SETTIMG);

  // list start clears history and image, so no sequence survives it
  assign tex_hit = !ls_r && (op == OP_SETTILESIZE) && tex_seq;
  assign pal_hit = !ls_r && (op == OP_LOADTLUT) && pal_seq &&
                   ((img_fmt_r == FMT_RGBA) || (img_fmt_r == FMT_IA)) &&
                   (img_bs_r == SIZ_16B);

  assign table_room = (cnt_r < SEEN_CW'(SEEN_DEPTH));

  assign stat.cand     = (tex_hit || pal_hit) && (img_seg_r[31:24] == SEG_TEXTURE);
  assign stat.scan_end = (idx_r >= cnt_r);
  assign stat.hit      = (rd_data_r == st_addr_r);
  assign stat.out_free = !out_valid || out_ready;

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hi_r <= in_word_high;
      lo_r <= in_word_low;
      ls_r <= in_list_start;
    end
  end

  // history, tile table and image state; list start clears what the command leaves alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_LEN; i++) hist_r[i] <= '0;
      for (int i = 0; i < TILE_SLOTS; i++) begin
        tile_fmt_r[i] <= '0;
        tile_bs_r[i]  <= '0;
      end
      img_fmt_r <= '0;
      img_bs_r  <= '0;
      img_seg_r <= '0;
    end else if (cmd.decode) begin
      // tile descriptors
      for (int i = 0; i < TILE_SLOTS; i++) begin
        if ((op == OP_SETTILE) && (tile_idx == TILE_AW'(i))) begin
          tile_fmt_r[i] <= hi_r[23:21];
          tile_bs_r[i]  <= hi_r[20:19];
        end else if (ls_r) begin
          tile_fmt_r[i] <= '0;
          tile_bs_r[i]  <= '0;
        end
      end
      // current image
      if (op == OP_SETTIMG) begin
        img_fmt_r <= hi_r[23:21];
        img_bs_r  <= hi_r[20:19];
        img_seg_r <= lo_r;
      end else if (ls_r) begin
        img_fmt_r <= '0;
        img_bs_r  <= '0;
        img_seg_r <= '0;
      end
      // end of list leaves the history alone, unless list start clears it
      if (op != OP_ENDDL) begin
        for (int i = 1; i < HIST_LEN; i++) hist_r[i] <= ls_r ? 8'd0 : hist_r[i-1];
        hist_r[0] <= op;
      end else if (ls_r) begin
        for (int i = 0; i < HIST_LEN; i++) hist_r[i] <= '0;
      end
    end
  end

  // stage the candidate reference
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      st_kind_r <= pal_hit ? KIND_PALETTE : KIND_TEXTURE;
      st_addr_r <= img_seg_r;
      st_w_r    <= pal_hit ? 11'd0 : dim_w;
      st_h_r    <= pal_hit ? 11'd0 : dim_h;
      st_prod_r <= 21'(dim_w * dim_h);
      st_cnt_r  <= pal_hit ? dim_w : 11'd0;
      st_fmt_r  <= tile_fmt_r[tile_idx];
      st_bs_r   <= pal_hit ? SIZ_16B : tile_bs_r[tile_idx];
    end
  end

  // search index over the seen table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.decode) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + SEEN_CW'(1);
      if (cmd.emit && table_room) cnt_r <= cnt_r + SEEN_CW'(1);
    end
  end

  // seen table memory
  always_ff @(posedge clk) begin
    if (cmd.emit && table_room) seen_mem[cnt_r[SEEN_AW-1:0]] <= st_addr_r;
    if (cmd.rd_issue) rd_data_r <= seen_mem[idx_r[SEEN_AW-1:0]];
  end

  // byte size from texel count and texel size, or from the palette entry count
  always_comb begin
    byte_nxt = '0;
    if (st_kind_r == KIND_PALETTE) begin
      byte_nxt = {11'd0, st_cnt_r, 1'b0};
    end else begin
      case (st_bs_r)
        SIZ_4B:  byte_nxt = {3'd0, st_prod_r[20:1]};
        SIZ_8B:  byte_nxt = {2'd0, st_prod_r};
        SIZ_16B: byte_nxt = {1'b0, st_prod_r, 1'b0};
        SIZ_32B: byte_nxt = {st_prod_r, 2'b00};
        default: byte_nxt = '0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ref_kind        <= st_kind_r;
      out_segment_address <= st_addr_r;
      out_width           <= st_w_r;
      out_height          <= st_h_r;
      out_byte_size       <= byte_nxt;
      out_palette_count   <= st_cnt_r;
      out_pixel_format    <= st_fmt_r;
      out_bit_size        <= st_bs_r;
      out_not_recorded    <= !table_room;
    end
  end

  // table fill never passes its depth
  `DLTR_ASSERT(a_cnt_bound, cnt_r <= SEEN_CW'(SEEN_DEPTH), "seen count beyond table depth")
  // a hand-off always lands in the result register
  `DLTR_ASSERT_IF(a_emit_lands, cmd.emit, ##1 out_valid, "emitted reference not presented")

endmodule

// ===== hdl/display_list_texture_ref_scanner_top.sv =====
// ----------------------------------------------------------------------------
// display_list_texture_ref_scanner_top
// texture and palette reference scanner for a graphics command stream
// ----------------------------------------------------------------------------
// One transaction on the in_ channel carries a 64-bit command (in_word_high,
// in_word_low) and in_list_start, which clears history, tile and image state
// ahead of that command. Each command yields zero or one transaction on the
// out_ channel describing a newly seen segment-2 texture or palette.
// A command that makes no reference passes through capture, then decode.
// A matching load sequence walks the seen table, a memory read and then a
// compare per stored entry; a match drops the reference, else the walk closes
// and hands the reference to the result register, the result turning valid
// in the same cycle that in_ready rises again.
// The result register lets the next command be accepted while a reference
// waits; if the receiver stalls, a later reference holds the block in its
// hand-off step and input is not accepted until the register frees.
// Reset clears the list state, the result valid and the seen table fill
// count; table entries past the fill count are never read, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module display_list_texture_ref_scanner_top
  import dltr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word_high,
  input  logic [31:0] in_word_low,
  input  logic        in_list_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ref_kind,
  output logic [31:0] out_segment_address,
  output logic [10:0] out_width,
  output logic [10:0] out_height,
  output logic [22:0] out_byte_size,
  output logic [10:0] out_palette_count,
  output logic [2:0]  out_pixel_format,
  output logic [1:0]  out_bit_size,
  output logic        out_not_recorded
);

  dltr_cmd_t  cmd;
  dltr_stat_t stat;

  // sequencer
  dltr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, table and result register
  dltr_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_word_high        (in_word_high),
    .in_word_low         (in_word_low),
    .in_list_start       (in_list_start),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_ref_kind        (out_ref_kind),
    .out_segment_address (out_segment_address),
    .out_width           (out_width),
    .out_height          (out_height),
    .out_byte_size       (out_byte_size),
    .out_palette_count   (out_palette_count),
    .out_pixel_format    (out_pixel_format),
    .out_bit_size        (out_bit_size),
    .out_not_recorded    (out_not_recorded)
  );

endmodule
